// ----- src/pid_line_follow_drive_controller_unit_assert.svh -----
// Assertion macros for the line follow drive controller.
// They sample on clk and are disabled while arst_n is low.
`ifndef PID_LINE_FOLLOW_DRIVE_CONTROLLER_UNIT_ASSERT_SVH
`define PID_LINE_FOLLOW_DRIVE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication
`define PLDC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pldc assertion failed");

// Next-cycle implication
`define PLDC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pldc assertion failed");

`endif

// ----- src/pldc_pkg.sv -----
`timescale 1ns / 1ps

package pldc_pkg;

	// Default integrator width
	localparam int INTEGRAL_WIDTH_DEFAULT = 24;

	// Field widths
	localparam int POS_W   = 16;
	localparam int SPEED_W = 15;
	localparam int GAIN_W  = 12;
	localparam int CODE_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Gains are Q.4, power saturates at 20 bits
	localparam int GAIN_FRAC_BITS = 4;
	localparam int POWER_W        = 20;
	localparam int WHEEL_W        = 22;

	// floor(x / 3) = (x * 43691) >> 17 for x below 2^17
	localparam int THIRD_SHIFT = 17;
	localparam logic [16:0] THIRD_RECIP = 17'd43691;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_THR   = 3'd5;

	// Register reset values
	localparam logic [SPEED_W-1:0]        BASE_SPEED_RST = 15'd4915;
	localparam logic signed [POS_W-1:0]   MIN_SPEED_RST  = 16'sd0;
	localparam logic [GAIN_W-1:0]         GAIN_P_RST     = 12'd16;
	localparam logic [GAIN_W-1:0]         GAIN_I_RST     = 12'd0;
	localparam logic [GAIN_W-1:0]         GAIN_D_RST     = 12'd320;
	localparam logic [SPEED_W-1:0]        TURN_THR_RST   = 15'd9830;

	// Command codes
	localparam logic [CODE_W-1:0] CMD_STOP      = 3'd0;
	localparam logic [CODE_W-1:0] CMD_FORWARD   = 3'd1;
	localparam logic [CODE_W-1:0] CMD_BACKWARD  = 3'd2;
	localparam logic [CODE_W-1:0] CMD_SPIN_LEFT = 3'd3;
	localparam logic [CODE_W-1:0] CMD_SPIN_RIGHT = 3'd4;
	localparam logic [CODE_W-1:0] CMD_MANUAL    = 3'd5;
	localparam logic [CODE_W-1:0] CMD_AUTO      = 3'd6;
	localparam logic [CODE_W-1:0] CMD_HALT      = 3'd7;

	// Status pin codes
	localparam logic [CODE_W-1:0] ST_STRAIGHT = 3'd3;
	localparam logic [CODE_W-1:0] ST_RIGHT    = 3'd5;
	localparam logic [CODE_W-1:0] ST_LEFT     = 3'd6;

	// Per-item mode info carried down the pipe
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              manual;
	} mode_t;

endpackage

// ----- src/pldc_if.sv -----
`timescale 1ns / 1ps

// Input channel: one loop sample
interface pldc_in_if;
	import pldc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CODE_W-1:0]        command_code;
	logic signed [POS_W-1:0]  line_offset;

	modport source (output valid, command_code, line_offset, input ready);
	modport sink   (input valid, command_code, line_offset, output ready);
endinterface

// Output channel: drive result
interface pldc_out_if;
	import pldc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  left_drive;
	logic signed [POS_W-1:0]  right_drive;
	logic                     drive_updated;
	logic [CODE_W-1:0]        status_pins;
	logic                     manual_active;

	modport source (output valid, left_drive, right_drive, drive_updated, status_pins,
		manual_active, input ready);
	modport sink   (input valid, left_drive, right_drive, drive_updated, status_pins,
		manual_active, output ready);
endinterface

// ----- src/pldc_integ.sv -----
`timescale 1ns / 1ps

// Input register, mode flag, previous position and saturating integrator.
module pldc_integ #(
	parameter int INTEGRAL_WIDTH = pldc_pkg::INTEGRAL_WIDTH_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic [pldc_pkg::CODE_W-1:0]              in_code,
	input  logic signed [pldc_pkg::POS_W-1:0]        in_pos,
	output logic                                     in_ready,
	input  logic                                     load_s2,
	output logic                                     valid_s2,
	output pldc_pkg::mode_t                          mode_s2,
	output logic signed [pldc_pkg::POS_W-1:0]        pos_s2,
	output logic signed [INTEGRAL_WIDTH-1:0]         integ_s2,
	output logic signed [pldc_pkg::POS_W:0]          deriv_s2
);
	import pldc_pkg::*;

	logic                       valid_s1;
	logic [CODE_W-1:0]          code_s1;
	logic signed [POS_W-1:0]    pos_s1;

	logic                       manual_q;
	logic signed [POS_W-1:0]    prev_q;
	logic signed [INTEGRAL_WIDTH-1:0] integ_q;

	logic                       manual_n;
	logic                       clear;
	logic signed [POS_W-1:0]    prev_eff;
	logic signed [INTEGRAL_WIDTH-1:0] integ_eff;
	logic signed [INTEGRAL_WIDTH:0]   isum;
	logic signed [INTEGRAL_WIDTH-1:0] integ_n;
	logic signed [POS_W:0]      deriv_n;
	logic                       fire;

	assign in_ready = !valid_s1 || load_s2;
	assign fire     = valid_s1 && load_s2;

	// Mode select, code 6 clears history
	always_comb begin
		clear    = (code_s1 == CMD_AUTO);
		manual_n = manual_q;
		if (code_s1 == CMD_MANUAL) begin
			manual_n = 1'b1;
		end else if (clear) begin
			manual_n = 1'b0;
		end
		prev_eff  = clear ? '0 : prev_q;
		integ_eff = clear ? '0 : integ_q;
	end

	// Difference and saturating accumulate
	always_comb begin
		deriv_n = {pos_s1[POS_W-1], pos_s1} - {prev_eff[POS_W-1], prev_eff};
		isum    = {integ_eff[INTEGRAL_WIDTH-1], integ_eff}
			+ {{(INTEGRAL_WIDTH+1-POS_W){pos_s1[POS_W-1]}}, pos_s1};
		if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
			integ_n = isum[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
				: {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
		end else begin
			integ_n = isum[INTEGRAL_WIDTH-1:0];
		end
	end

	// Pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	// Loop state, updated as an item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_q <= 1'b1;
			prev_q   <= '0;
			integ_q  <= '0;
		end else if (fire) begin
			manual_q <= manual_n;
			if (!manual_n) begin
				prev_q  <= pos_s1;
				integ_q <= integ_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready) begin
			code_s1 <= in_code;
			pos_s1  <= in_pos;
		end
		if (load_s2) begin
			mode_s2.code   <= code_s1;
			mode_s2.manual <= manual_n;
			pos_s2         <= pos_s1;
			integ_s2       <= integ_n;
			deriv_s2       <= deriv_n;
		end
	end

endmodule

// ----- src/pldc_mult.sv -----
`timescale 1ns / 1ps

// Gain products and the manual one-third speed, registered.
module pldc_mult #(
	parameter int INTEGRAL_WIDTH = pldc_pkg::INTEGRAL_WIDTH_DEFAULT
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          load_s3,
	input  logic                                          valid_s2,
	input  pldc_pkg::mode_t                               mode_s2,
	input  logic signed [pldc_pkg::POS_W-1:0]             pos_s2,
	input  logic signed [INTEGRAL_WIDTH-1:0]              integ_s2,
	input  logic signed [pldc_pkg::POS_W:0]               deriv_s2,
	input  logic [pldc_pkg::GAIN_W-1:0]                   gain_p,
	input  logic [pldc_pkg::GAIN_W-1:0]                   gain_i,
	input  logic [pldc_pkg::GAIN_W-1:0]                   gain_d,
	input  logic [pldc_pkg::SPEED_W-1:0]                  base_speed,
	output logic                                          valid_s3,
	output pldc_pkg::mode_t                               mode_s3,
	output logic signed [pldc_pkg::POS_W+pldc_pkg::GAIN_W:0]   pp_s3,
	output logic signed [INTEGRAL_WIDTH+pldc_pkg::GAIN_W:0]    ip_s3,
	output logic signed [pldc_pkg::POS_W+pldc_pkg::GAIN_W+1:0] dp_s3,
	output logic [pldc_pkg::SPEED_W-1:0]                  third_s3
);
	import pldc_pkg::*;

	localparam int PP_W = POS_W + GAIN_W + 1;
	localparam int IP_W = INTEGRAL_WIDTH + GAIN_W + 1;
	localparam int DP_W = POS_W + GAIN_W + 2;
	localparam int TP_W = SPEED_W + THIRD_SHIFT;

	logic signed [PP_W-1:0] pp_c;
	logic signed [IP_W-1:0] ip_c;
	logic signed [DP_W-1:0] dp_c;
	logic [TP_W-1:0]        tp_c;

	// Three independent signed products
	assign pp_c = $signed({1'b0, gain_p}) * pos_s2;
	assign ip_c = $signed({1'b0, gain_i}) * integ_s2;
	assign dp_c = $signed({1'b0, gain_d}) * deriv_s2;

	// base / 3 by reciprocal
	assign tp_c = TP_W'(base_speed) * TP_W'(THIRD_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			mode_s3  <= mode_s2;
			pp_s3    <= pp_c;
			ip_s3    <= ip_c;
			dp_s3    <= dp_c;
			third_s3 <= tp_c[TP_W-1:THIRD_SHIFT];
		end
	end

endmodule

// ----- src/pldc_mix.sv -----
`timescale 1ns / 1ps

// PID sum, power saturation, wheel clamps, status and the held result register.
module pldc_mix #(
	parameter int INTEGRAL_WIDTH = pldc_pkg::INTEGRAL_WIDTH_DEFAULT
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          valid_s3,
	input  pldc_pkg::mode_t                               mode_s3,
	input  logic signed [pldc_pkg::POS_W+pldc_pkg::GAIN_W:0]   pp_s3,
	input  logic signed [INTEGRAL_WIDTH+pldc_pkg::GAIN_W:0]    ip_s3,
	input  logic signed [pldc_pkg::POS_W+pldc_pkg::GAIN_W+1:0] dp_s3,
	input  logic [pldc_pkg::SPEED_W-1:0]                  third_s3,
	input  logic [pldc_pkg::SPEED_W-1:0]                  base_speed,
	input  logic signed [pldc_pkg::POS_W-1:0]             min_speed,
	input  logic [pldc_pkg::SPEED_W-1:0]                  turn_threshold,
	output logic                                          load_ok,
	input  logic                                          res_ready,
	output logic                                          res_valid,
	output logic signed [pldc_pkg::POS_W-1:0]             left_q,
	output logic signed [pldc_pkg::POS_W-1:0]             right_q,
	output logic                                          updated_q,
	output logic [pldc_pkg::CODE_W-1:0]                   status_q,
	output logic                                          manual_q
);
	import pldc_pkg::*;

	localparam int SUM_W = INTEGRAL_WIDTH + GAIN_W + 5;
	localparam int SHF_W = SUM_W - GAIN_FRAC_BITS;

	logic signed [SUM_W-1:0]   sum_c;
	logic signed [SHF_W-1:0]   shf_c;
	logic [SHF_W-POWER_W:0]    top_c;
	logic signed [POWER_W-1:0] power_c;
	logic signed [WHEEL_W-1:0] base_w;
	logic signed [WHEEL_W-1:0] min_w;
	logic signed [WHEEL_W-1:0] right_raw;
	logic signed [WHEEL_W-1:0] left_raw;
	logic signed [WHEEL_W-1:0] right_cl;
	logic signed [WHEEL_W-1:0] left_cl;
	logic signed [POWER_W:0]   dir_c;
	logic signed [POWER_W:0]   thr_c;
	logic                      above_lo;
	logic                      below_hi;
	logic signed [POS_W-1:0]   sp_c;
	logic signed [POS_W-1:0]   tr_c;
	logic signed [POS_W-1:0]   left_n;
	logic signed [POS_W-1:0]   right_n;
	logic                      updated_n;
	logic [CODE_W-1:0]         status_n;

	assign load_ok = !res_valid || res_ready;

	// PID sum, floor divide by 16, saturate to power width
	always_comb begin
		sum_c = SUM_W'(pp_s3) + SUM_W'(ip_s3) + SUM_W'(dp_s3);
		shf_c = sum_c[SUM_W-1:GAIN_FRAC_BITS];
		top_c = shf_c[SHF_W-1:POWER_W-1];
		if ((&top_c) || !(|top_c)) begin
			power_c = shf_c[POWER_W-1:0];
		end else begin
			power_c = shf_c[SHF_W-1] ? {1'b1, {(POWER_W-1){1'b0}}}
				: {1'b0, {(POWER_W-1){1'b1}}};
		end
	end

	// Wheel mix and clamps: lower clamp first
	always_comb begin
		base_w    = WHEEL_W'($signed({1'b0, base_speed}));
		min_w     = WHEEL_W'(min_speed);
		right_raw = base_w + WHEEL_W'(power_c);
		left_raw  = base_w - WHEEL_W'(power_c);
		if (right_raw < min_w) right_cl = min_w;
		else if (right_raw > base_w) right_cl = base_w;
		else right_cl = right_raw;
		if (left_raw < min_w) left_cl = min_w;
		else if (left_raw > base_w) left_cl = base_w;
		else left_cl = left_raw;
	end

	// Direction against threshold
	always_comb begin
		dir_c    = {power_c, 1'b0};
		thr_c    = $signed({{(POWER_W+1-SPEED_W){1'b0}}, turn_threshold});
		above_lo = dir_c > -thr_c;
		below_hi = dir_c < thr_c;
	end

	// Next held values
	always_comb begin
		sp_c      = $signed({1'b0, base_speed});
		tr_c      = $signed({1'b0, third_s3});
		left_n    = left_q;
		right_n   = right_q;
		updated_n = 1'b0;
		status_n  = status_q;
		if (mode_s3.manual) begin
			updated_n = 1'b1;
			case (mode_s3.code)
				CMD_STOP, CMD_HALT: begin
					left_n  = '0;
					right_n = '0;
				end
				CMD_FORWARD: begin
					left_n  = sp_c;
					right_n = sp_c;
				end
				CMD_BACKWARD: begin
					left_n  = -sp_c;
					right_n = -sp_c;
				end
				CMD_SPIN_LEFT: begin
					left_n  = -tr_c;
					right_n = tr_c;
				end
				CMD_SPIN_RIGHT: begin
					left_n  = tr_c;
					right_n = -tr_c;
				end
				default: begin
					updated_n = 1'b0;
				end
			endcase
		end else begin
			updated_n = 1'b1;
			left_n    = left_cl[POS_W-1:0];
			right_n   = right_cl[POS_W-1:0];
			if (above_lo && below_hi) status_n = ST_STRAIGHT;
			else if (above_lo) status_n = ST_RIGHT;
			else if (below_hi) status_n = ST_LEFT;
		end
	end

	// Result register; its drive and status fields are the held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			left_q    <= '0;
			right_q   <= '0;
			updated_q <= 1'b0;
			status_q  <= '0;
			manual_q  <= 1'b1;
		end else if (load_ok) begin
			res_valid <= valid_s3;
			if (valid_s3) begin
				left_q    <= left_n;
				right_q   <= right_n;
				updated_q <= updated_n;
				status_q  <= status_n;
				manual_q  <= mode_s3.manual;
			end
		end
	end

endmodule

// ----- src/pid_line_follow_drive_controller_unit.sv -----
`timescale 1ns / 1ps
// Line-following differential drive controller.
// sample (sink): one loop iteration per transfer, command_code and line_offset.
// result (source): one transfer per sample with the held left/right drives,
//   drive_updated, the held status pins and the manual mode flag.
// cfg_we/cfg_index/cfg_data: register write port, one write per cycle with
//   cfg_we high; write only while no sample is in flight.
// Pipeline: the input register feeds the integrator, gain multiply and result registers.
// Throughput: one sample per cycle unless result is held off; the integrator and
//   previous position close their loop in the first stage, the multiplies sit in theirs.
// Reset: manual mode, drives and status zero, integrator and previous
//   position cleared, registers at their defaults. No clearing pass.
// Stall: while result is held off, items move up into empty stages, so
//   sample.ready stays high until every stage holds an item; nothing is lost.
`include "pid_line_follow_drive_controller_unit_assert.svh"

module pid_line_follow_drive_controller_unit #(
	parameter int INTEGRAL_WIDTH = pldc_pkg::INTEGRAL_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pldc_in_if.sink                              sample,
	pldc_out_if.source                           result,
	input  logic                                 cfg_we,
	input  logic [pldc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pldc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pldc_pkg::*;

	// Configuration registers
	logic [SPEED_W-1:0]       base_q;
	logic signed [POS_W-1:0]  min_q;
	logic [GAIN_W-1:0]        gain_p_q;
	logic [GAIN_W-1:0]        gain_i_q;
	logic [GAIN_W-1:0]        gain_d_q;
	logic [SPEED_W-1:0]       thr_q;

	// Stage links
	logic                              load_s2;
	logic                              load_s3;
	logic                              load_ok;
	logic                              valid_s2;
	logic                              valid_s3;
	mode_t                             mode_s2;
	mode_t                             mode_s3;
	logic signed [POS_W-1:0]           pos_s2;
	logic signed [INTEGRAL_WIDTH-1:0]  integ_s2;
	logic signed [POS_W:0]             deriv_s2;
	logic signed [POS_W+GAIN_W:0]      pp_s3;
	logic signed [INTEGRAL_WIDTH+GAIN_W:0] ip_s3;
	logic signed [POS_W+GAIN_W+1:0]    dp_s3;
	logic [SPEED_W-1:0]                third_s3;

	// Result fields
	logic                     res_valid;
	logic signed [POS_W-1:0]  left_w;
	logic signed [POS_W-1:0]  right_w;
	logic                     updated_w;
	logic [CODE_W-1:0]        status_w;
	logic                     manual_w;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_SPEED_RST;
			min_q    <= MIN_SPEED_RST;
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
			thr_q    <= TURN_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_SPEED: base_q   <= cfg_data[SPEED_W-1:0];
				REG_MIN_SPEED:  min_q    <= $signed(cfg_data[POS_W-1:0]);
				REG_GAIN_P:     gain_p_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     gain_i_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     gain_d_q <= cfg_data[GAIN_W-1:0];
				REG_TURN_THR:   thr_q    <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage advance: a stage loads when it is empty or its item moves on
	assign load_s3 = !valid_s3 || load_ok;
	assign load_s2 = !valid_s2 || load_s3;

	pldc_integ #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_integ (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_code  (sample.command_code),
		.in_pos   (sample.line_offset),
		.in_ready (sample.ready),
		.load_s2  (load_s2),
		.valid_s2 (valid_s2),
		.mode_s2  (mode_s2),
		.pos_s2   (pos_s2),
		.integ_s2 (integ_s2),
		.deriv_s2 (deriv_s2)
	);

	pldc_mult #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_s3    (load_s3),
		.valid_s2   (valid_s2),
		.mode_s2    (mode_s2),
		.pos_s2     (pos_s2),
		.integ_s2   (integ_s2),
		.deriv_s2   (deriv_s2),
		.gain_p     (gain_p_q),
		.gain_i     (gain_i_q),
		.gain_d     (gain_d_q),
		.base_speed (base_q),
		.valid_s3   (valid_s3),
		.mode_s3    (mode_s3),
		.pp_s3      (pp_s3),
		.ip_s3      (ip_s3),
		.dp_s3      (dp_s3),
		.third_s3   (third_s3)
	);

	pldc_mix #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_mix (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s3       (valid_s3),
		.mode_s3        (mode_s3),
		.pp_s3          (pp_s3),
		.ip_s3          (ip_s3),
		.dp_s3          (dp_s3),
		.third_s3       (third_s3),
		.base_speed     (base_q),
		.min_speed      (min_q),
		.turn_threshold (thr_q),
		.load_ok        (load_ok),
		.res_ready      (result.ready),
		.res_valid      (res_valid),
		.left_q         (left_w),
		.right_q        (right_w),
		.updated_q      (updated_w),
		.status_q       (status_w),
		.manual_q       (manual_w)
	);

	// Result channel
	assign result.valid         = res_valid;
	assign result.left_drive    = left_w;
	assign result.right_drive   = right_w;
	assign result.drive_updated = updated_w;
	assign result.status_pins   = status_w;
	assign result.manual_active = manual_w;

	// Automatic items always set new drives
	`PLDC_ASSERT_IMP(a_auto_updates, res_valid && !manual_w, updated_w)

	// Manual drives are equal or opposite
	`PLDC_ASSERT_IMP(a_manual_pair, res_valid && manual_w && updated_w,
		(left_w == right_w) || (POS_W'(left_w + right_w) == '0))

	// The automatic left drive sits inside the clamp window, or at a clamp when min is above base
	`PLDC_ASSERT_IMP(a_auto_clamp, res_valid && !manual_w,
		(left_w == min_q) || (left_w == $signed({1'b0, base_q}))
		|| ((left_w >= min_q) && (left_w <= $signed({1'b0, base_q}))))

	// A base speed write lands in its register
	`PLDC_ASSERT_NXT(a_cfg_base, cfg_we && (cfg_index == REG_BASE_SPEED),
		base_q == $past(cfg_data[SPEED_W-1:0]))

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import pldc_pkg::*;

	localparam int INTEG_W     = INTEGRAL_WIDTH_DEFAULT;
	localparam int HOLD_CYCLES = 60;

	// One drive result as seen on the result channel
	typedef struct packed {
		logic signed [POS_W-1:0] left_drive;
		logic signed [POS_W-1:0] right_drive;
		logic                    drive_updated;
		logic [CODE_W-1:0]       status_pins;
		logic                    manual_active;
	} drive_result_t;

	// Controller state mirror plus the queue of drive results still owed
	class drive_tracker;
		longint base_spd, min_spd, kp, ki, kd, thr;
		logic   manual;
		longint prev_pos, integ_sum, held_left, held_right;
		logic [CODE_W-1:0] held_status;
		drive_result_t expected_drives[$];
		int errors;

		function new();
			base_spd = BASE_SPEED_RST;
			min_spd = MIN_SPEED_RST;
			kp = GAIN_P_RST;
			ki = GAIN_I_RST;
			kd = GAIN_D_RST;
			thr = TURN_THR_RST;
			manual = 1'b1;
			prev_pos = 0;
			integ_sum = 0;
			held_left = 0;
			held_right = 0;
			held_status = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BASE_SPEED: base_spd = data[SPEED_W-1:0];
				REG_MIN_SPEED:  min_spd = $signed(data);
				REG_GAIN_P:     kp = data[GAIN_W-1:0];
				REG_GAIN_I:     ki = data[GAIN_W-1:0];
				REG_GAIN_D:     kd = data[GAIN_W-1:0];
				REG_TURN_THR:   thr = data[SPEED_W-1:0];
				default: ;
			endcase
		endfunction

		// Lower clamp wins over upper, then 16-bit saturation
		function longint clamp_wheel(longint v);
			if (v < min_spd) v = min_spd;
			else if (v > base_spd) v = base_spd;
			if (v > 32767) v = 32767;
			else if (v < -32768) v = -32768;
			return v;
		endfunction

		// Advance the mirror by one accepted sample and queue its drive result
		function void predict_drive(logic [CODE_W-1:0] code, logic signed [POS_W-1:0] pos);
			drive_result_t r;
			longint p, third, deriv, integ, sum, power, dir, ilim, plim;
			logic upd;
			p = pos;
			upd = 1'b0;
			ilim = 64'sd1 <<< (INTEG_W - 1);
			plim = 64'sd1 <<< (POWER_W - 1);
			if (code == CMD_MANUAL) begin
				manual = 1'b1;
			end else if (code == CMD_AUTO) begin
				manual = 1'b0;
				prev_pos = 0;
				integ_sum = 0;
			end
			if (manual) begin
				third = base_spd / 3;
				upd = 1'b1;
				case (code)
					CMD_STOP, CMD_HALT: begin
						held_left = 0;
						held_right = 0;
					end
					CMD_FORWARD: begin
						held_left = base_spd;
						held_right = base_spd;
					end
					CMD_BACKWARD: begin
						held_left = -base_spd;
						held_right = -base_spd;
					end
					CMD_SPIN_LEFT: begin
						held_left = -third;
						held_right = third;
					end
					CMD_SPIN_RIGHT: begin
						held_left = third;
						held_right = -third;
					end
					default: upd = 1'b0;
				endcase
			end else begin
				deriv = p - prev_pos;
				integ = integ_sum + p;
				if (integ > ilim - 1) integ = ilim - 1;
				else if (integ < -ilim) integ = -ilim;
				integ_sum = integ;
				prev_pos = p;
				sum = kp * p + ki * integ + kd * deriv;
				// arithmetic shift gives the floor of sum / 16
				power = sum >>> GAIN_FRAC_BITS;
				if (power > plim - 1) power = plim - 1;
				else if (power < -plim) power = -plim;
				held_right = clamp_wheel(base_spd + power);
				held_left = clamp_wheel(base_spd - power);
				upd = 1'b1;
				// status uses the saturated power before the wheel clamps; zero threshold and zero dir holds
				dir = 2 * power;
				if (dir > -thr && dir < thr) held_status = ST_STRAIGHT;
				else if (dir > -thr) held_status = ST_RIGHT;
				else if (dir < thr) held_status = ST_LEFT;
			end
			r.left_drive = 16'(held_left);
			r.right_drive = 16'(held_right);
			r.drive_updated = upd;
			r.status_pins = held_status;
			r.manual_active = manual;
			expected_drives.push_back(r);
		endfunction

		function void check_drive(drive_result_t got);
			drive_result_t want;
			if (expected_drives.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected drive transfer L=%0d R=%0d upd=%0b st=%0d man=%0b",
						$realtime, got.left_drive, got.right_drive, got.drive_updated,
						got.status_pins, got.manual_active);
				return;
			end
			want = expected_drives.pop_front();
			if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
					got.drive_updated !== want.drive_updated ||
					got.status_pins !== want.status_pins ||
					got.manual_active !== want.manual_active) begin
				errors++;
				if (errors <= 10)
					$display("%0t: drive mismatch exp L=%0d R=%0d upd=%0b st=%0d man=%0b",
						$realtime, want.left_drive, want.right_drive, want.drive_updated,
						want.status_pins, want.manual_active,
						" got L=%0d R=%0d upd=%0b st=%0d man=%0b",
						got.left_drive, got.right_drive, got.drive_updated,
						got.status_pins, got.manual_active);
			end
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pldc_in_if  sample_ch ();
	pldc_out_if result_ch ();

	pid_line_follow_drive_controller_unit #(
		.INTEGRAL_WIDTH(INTEG_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	drive_tracker track;

	// Codes that only steer in manual mode
	logic [CODE_W-1:0] drive_cmds [6] = '{CMD_STOP, CMD_FORWARD, CMD_BACKWARD,
		CMD_SPIN_LEFT, CMD_SPIN_RIGHT, CMD_HALT};

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;

	always #1 clk = ~clk;

	// Receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watch both channels: predict on sample transfers, check result transfers
	always @(posedge clk) begin
		drive_result_t got;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				track.predict_drive(sample_ch.command_code, sample_ch.line_offset);
			if (result_ch.valid && result_ch.ready) begin
				got.left_drive = result_ch.left_drive;
				got.right_drive = result_ch.right_drive;
				got.drive_updated = result_ch.drive_updated;
				got.status_pins = result_ch.status_pins;
				got.manual_active = result_ch.manual_active;
				track.check_drive(got);
			end
		end
	end

	// Offer one sample, possibly after an idle gap, and wait for its transfer
	task automatic send_sample(input logic [CODE_W-1:0] code,
			input logic signed [POS_W-1:0] pos);
		if ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.command_code <= code;
		sample_ch.line_offset <= pos;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Stop offering and wait until every owed result has come out
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (track.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		track.set_reg(idx, data);
	endtask

	task automatic load_registers(input int base, input int min_s, input int kp,
			input int ki, input int kd, input int thr);
		write_reg(REG_BASE_SPEED, 16'(base));
		write_reg(REG_MIN_SPEED, 16'(min_s));
		write_reg(REG_GAIN_P, 16'(kp));
		write_reg(REG_GAIN_I, 16'(ki));
		write_reg(REG_GAIN_D, 16'(kd));
		write_reg(REG_TURN_THR, 16'(thr));
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [POS_W-1:0] rand_position();
		int v;
		case ($urandom_range(9))
			0: v = $urandom;
			1: begin
				case ($urandom_range(4))
					0: v = -16384;
					1: v = 16384;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			default: v = int'($urandom_range(32768)) - 16384;
		endcase
		return v[POS_W-1:0];
	endfunction

	function automatic logic [CODE_W-1:0] rand_command();
		int r;
		r = $urandom_range(99);
		if (r < 5) return CMD_MANUAL;
		if (r < 10) return CMD_AUTO;
		return drive_cmds[$urandom_range(5)];
	endfunction

	task automatic run_mixed(input int n);
		for (int k = 0; k < n; k++) send_sample(rand_command(), rand_position());
	endtask

	// Long auto run with large same-sign offsets to drive the integral to its limit
	task automatic run_windup(input int n, input bit negative);
		int v;
		send_sample(CMD_AUTO, rand_position());
		for (int k = 0; k < n; k++) begin
			v = int'($urandom_range(32767, 30000));
			if (negative) v = -v - 1;
			send_sample(drive_cmds[$urandom_range(5)], v[POS_W-1:0]);
		end
	endtask

	// Overall time limit
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		track = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.command_code = '0;
		sample_ch.line_offset = '0;
		result_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every manual code, mode switches, position extremes
		send_sample(CMD_FORWARD, 16'sd0);
		send_sample(CMD_BACKWARD, -16'sd1);
		send_sample(CMD_SPIN_LEFT, 16'sd16384);
		send_sample(CMD_SPIN_RIGHT, -16'sd16384);
		send_sample(CMD_STOP, 16'sd0);
		send_sample(CMD_HALT, 16'sd0);
		send_sample(CMD_MANUAL, 16'sd5);
		send_sample(CMD_AUTO, 16'sd16384);
		// clear while already automatic
		send_sample(CMD_AUTO, -16'sd16384);
		send_sample(CMD_STOP, 16'sd32767);
		send_sample(CMD_HALT, -16'sd32768);
		send_sample(CMD_FORWARD, 16'sd0);
		send_sample(CMD_MANUAL, 16'sd0);
		send_sample(CMD_AUTO, 16'sd0);
		drain_results();

		// Zero threshold, zero base, min above base
		load_registers(0, 16384, 4095, 0, 0, 0);
		send_sample(CMD_AUTO, 16'sd0);
		send_sample(CMD_STOP, 16'sd0);
		send_sample(CMD_STOP, 16'sd1);
		send_sample(CMD_STOP, -16'sd1);
		send_sample(CMD_FORWARD, -16'sd1);
		send_sample(CMD_MANUAL, 16'sd0);
		send_sample(CMD_SPIN_LEFT, 16'sd0);
		send_sample(CMD_SPIN_RIGHT, 16'sd0);
		drain_results();

		// Random settings, no idling
		load_registers($urandom_range(16384), int'($urandom_range(32768)) - 16384,
			$urandom_range(64), $urandom_range(8), $urandom_range(400),
			$urandom_range(32767));
		run_mixed(150);
		drain_results();

		// Register extremes, sender idling
		load_registers(16384, -16384, 4095, 4095, 4095, 32767);
		src_idle_pct = 46;
		run_mixed(150);

		// Receiver holds off while the sender keeps offering
		src_idle_pct = 0;
		hold_req <= ~hold_req;
		run_mixed(20);
		drain_results();

		// Integral windup, receiver stalling
		load_registers(8192, -8192, 0, 1, 0, 16384);
		sink_stall_pct <= 46;
		run_windup(290, 1'b0);
		drain_results();

		// Negative windup, both sides idling
		src_idle_pct = 29;
		sink_stall_pct <= 29;
		run_windup(290, 1'b1);

		// Wind down
		sample_ch.valid <= 1'b0;
		for (int n = 0; track.pending() != 0 && n < 5000; n++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (track.errors == 0 && track.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
